>>> hw/rtl/lrup_pkg.sv
// Shared constants and types for the LRU page replacement block.
package lrup_pkg;

   localparam int FRAMES_DEF    = 16;
   localparam int PAGE_BITS_DEF = 16;
   localparam int CFG_W         = 5;
   localparam int SLOT_W        = 4;
   localparam int TOTAL_W       = 32;
   localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/lrup_if.sv
// Request and response channel interfaces of the LRU page replacement block.
interface lrup_req_if #(
   parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
);
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page;

   modport source (output valid, output page, input ready);
   modport sink   (input valid, input page, output ready);
endinterface

interface lrup_rsp_if #(
   parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lrup_pkg::SLOT_W-1:0]   slot;
   logic                          evicted_valid;
   logic [PAGE_BITS-1:0]          evicted_page;
   logic [lrup_pkg::TOTAL_W-1:0]  fault_total;
   logic [lrup_pkg::TOTAL_W-1:0]  hit_total;

   modport source (output valid, output hit, output slot, output evicted_valid,
                   output evicted_page, output fault_total, output hit_total,
                   input ready);
   modport sink   (input valid, input hit, input slot, input evicted_valid,
                   input evicted_page, input fault_total, input hit_total,
                   output ready);
endinterface

>>> hw/rtl/lru_page_replacement.sv
// LRU page replacement unit: frame table in a single-port-read memory, two passes per request.
//
// Each request is a page reference looked up among the active frames 0..n-1, where n is
// csr_write_data as last written (0 counts as 1, above FRAMES counts as FRAMES; reset 16).
// A hit makes the frame most recent; a miss fills the lowest empty active frame or else
// evicts the oldest one (lowest index on equal age). Hit and fault totals saturate.
// Page number and age of every frame live in one memory with a registered read; valid
// bits are flip-flops. A request makes a lookup pass and an age-update pass over the n
// active frames, one entry per cycle each, before the next request is accepted. A
// finished response waits in an output register while the next request is taken.
module lru_page_replacement #(
   parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [lrup_pkg::CFG_W-1:0]   csr_write_data,
   lrup_req_if.sink                     req_ch,
   lrup_rsp_if.source                   rsp_ch
);
   import lrup_pkg::*;

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int N_W    = (FRAMES > 1) ? $clog2(FRAMES + 1) : 1;
   localparam int CMP_W  = ((N_W > CFG_W) ? N_W : CFG_W) + 1;
   localparam int ENT_W  = PAGE_BITS + RANK_W;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

   state_type state_ff, state_in;

   logic [CFG_W-1:0]     fiu_ff;
   logic [FRAMES-1:0]    valid_ff;
   logic [ENT_W-1:0]     mem [FRAMES];
   logic [ENT_W-1:0]     rd_data_ff;

   logic                 iss_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 rdv_ff;
   logic [IDX_W-1:0]     rdi_ff;

   logic [PAGE_BITS-1:0] page_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     hit_slot_ff;
   logic [RANK_W-1:0]    hit_rank_ff;
   logic                 empty_ff;
   logic [IDX_W-1:0]     empty_slot_ff;
   logic [IDX_W-1:0]     best_slot_ff;
   logic [RANK_W-1:0]    best_rank_ff;
   logic [PAGE_BITS-1:0] evp_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_ev_ff;
   logic [PAGE_BITS-1:0] rsp_evp_ff;
   logic [TOTAL_W-1:0]   fault_cnt_ff;
   logic [TOTAL_W-1:0]   hit_cnt_ff;

   logic [CMP_W-1:0]     cfg_ext;
   logic [N_W-1:0]       n_act;
   logic [N_W-1:0]       last_idx;
   logic                 iss_last;
   logic                 proc_last;
   logic                 accept;
   logic                 out_free;
   logic                 start_pass;
   logic                 proc_scan;
   logic                 proc_upd;
   logic                 load_rsp;

   logic [PAGE_BITS-1:0] rd_page;
   logic [RANK_W-1:0]    rd_rank;
   logic [IDX_W-1:0]     used;
   logic [RANK_W-1:0]    limit;
   logic                 age_all;
   logic                 evict;
   logic [RANK_W-1:0]    new_rank;
   logic [PAGE_BITS-1:0] new_page;
   logic [SLOT_W+IDX_W-1:0] slot_ext;

   // active frame count and pass bookkeeping
   always_comb begin
      cfg_ext = CMP_W'(fiu_ff);
      if (fiu_ff == '0) begin
         n_act = N_W'(1);
      end else if (cfg_ext > CMP_W'(FRAMES)) begin
         n_act = N_W'(FRAMES);
      end else begin
         n_act = cfg_ext[N_W-1:0];
      end
      last_idx  = n_act - N_W'(1);
      iss_last  = (N_W'(idx_ff) == last_idx);
      proc_last = rdv_ff && (N_W'(rdi_ff) == last_idx);
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_ch.valid) state_in = ST_SCAN;
         ST_SCAN:   if (proc_last) state_in = ST_UPDATE;
         ST_UPDATE: if (proc_last) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      start_pass   = accept || ((state_ff == ST_SCAN) && proc_last);
      proc_scan    = (state_ff == ST_SCAN) && rdv_ff;
      proc_upd     = (state_ff == ST_UPDATE) && rdv_ff;
      load_rsp     = (state_ff == ST_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fiu_ff   <= FRAMES_IN_USE_RST;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) fiu_ff <= csr_write_data;
      end
   end

   // read issue and return
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_ff <= 1'b0;
         idx_ff <= '0;
         rdv_ff <= 1'b0;
         rdi_ff <= '0;
      end else begin
         rdv_ff <= iss_ff;
         rdi_ff <= idx_ff;
         if (start_pass) begin
            iss_ff <= 1'b1;
            idx_ff <= '0;
         end else if (iss_ff) begin
            if (iss_last) begin
               iss_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
      end
   end

   assign rd_page = rd_data_ff[ENT_W-1:RANK_W];
   assign rd_rank = rd_data_ff[RANK_W-1:0];

   // replacement decision
   always_comb begin
      evict   = !found_ff && !empty_ff;
      age_all = !found_ff && empty_ff;
      if (found_ff) begin
         used  = hit_slot_ff;
         limit = hit_rank_ff;
      end else if (empty_ff) begin
         used  = empty_slot_ff;
         limit = best_rank_ff;
      end else begin
         used  = best_slot_ff;
         limit = best_rank_ff;
      end
   end

   always_comb begin
      new_rank = rd_rank;
      new_page = rd_page;
      if (rdi_ff == used) begin
         new_rank = '0;
         if (!found_ff) new_page = page_ff;
      end else if (valid_ff[rdi_ff] && (age_all || (rd_rank < limit))
                   && (rd_rank != RANK_MAX)) begin
         new_rank = rd_rank + RANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (proc_upd) mem[rdi_ff] <= {new_page, new_rank};
      if (iss_ff) rd_data_ff <= mem[idx_ff];
   end

   // lookup pass
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else if (accept) begin
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else if (proc_scan) begin
         if (valid_ff[rdi_ff] && (rd_page == page_ff) && !found_ff) found_ff <= 1'b1;
         if (!valid_ff[rdi_ff] && !empty_ff) empty_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_ch.page;
         evp_ff  <= '0;
      end else if (proc_scan) begin
         if (valid_ff[rdi_ff] && (rd_page == page_ff) && !found_ff) begin
            hit_slot_ff <= rdi_ff;
            hit_rank_ff <= rd_rank;
         end
         if (!valid_ff[rdi_ff] && !empty_ff) empty_slot_ff <= rdi_ff;
         if ((rdi_ff == '0) || (rd_rank > best_rank_ff)) begin
            best_slot_ff <= rdi_ff;
            best_rank_ff <= rd_rank;
         end
      end else if (proc_upd && evict && (rdi_ff == used)) begin
         evp_ff <= rd_page;
      end
   end

   // response register and totals
   assign slot_ext = {SLOT_W'(0), used};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         fault_cnt_ff <= '0;
         hit_cnt_ff   <= '0;
      end else if (load_rsp) begin
         valid_ff[used] <= 1'b1;
         rsp_valid_ff   <= 1'b1;
         if (found_ff) begin
            if (hit_cnt_ff != '1) hit_cnt_ff <= hit_cnt_ff + TOTAL_W'(1);
         end else begin
            if (fault_cnt_ff != '1) fault_cnt_ff <= fault_cnt_ff + TOTAL_W'(1);
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_hit_ff  <= found_ff;
         rsp_slot_ff <= slot_ext[SLOT_W-1:0];
         rsp_ev_ff   <= evict;
         rsp_evp_ff  <= evp_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.slot          = rsp_slot_ff;
   assign rsp_ch.evicted_valid = rsp_ev_ff;
   assign rsp_ch.evicted_page  = rsp_evp_ff;
   assign rsp_ch.fault_total   = fault_cnt_ff;
   assign rsp_ch.hit_total     = hit_cnt_ff;

`ifndef SYNTHESIS
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> (N_W'(rdi_ff) < n_act))
      else $error("read beyond active frames");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.hit) |-> !rsp_ch.evicted_valid)
      else $error("eviction reported on a hit");

   a_used_valid: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> valid_ff[$past(used)])
      else $error("used frame not marked valid");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !proc_upd && !iss_ff)
      else $error("memory activity while idle");
`endif

endmodule
